FILE: src/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SW = $clog2(TASK_SLOTS);

  typedef enum logic [2:0] {
    CMD_SWITCH  = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_KILL    = 3'd2,
    CMD_EXIT    = 3'd3,
    CMD_SLEEP   = 3'd4,
    CMD_RECEIVE = 3'd5,
    CMD_SEND    = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    RS_OK        = 3'd0,
    RS_NO_PID    = 3'd1,
    RS_NOT_LISTN = 3'd2,
    RS_FULL      = 3'd3,
    RS_NO_MSG    = 3'd4,
    RS_NO_TASK   = 3'd5
  } rstat_t;

  typedef enum logic [1:0] {
    TS_READY     = 2'd0,
    TS_RUNNING   = 2'd1,
    TS_SLEEPING  = 2'd2,
    TS_LISTENING = 2'd3
  } tstat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] target_pid;
    logic [15:0] sleep_ticks;
    logic [31:0] msg_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_pid;
    logic [3:0]  current_slot_out;
    logic [31:0] run_count;
    logic [31:0] msg_out;
  } out_word_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] sleep;
    logic [1:0]  tstat;
    logic [31:0] runs;
  } slot_t;

endpackage

FILE: src/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task table with round-robin switch, sleep countdowns and mailboxes.
// ----------------------------------------------------------------------------
// One word in, one word out. Slot records live in a synchronous memory; each
// visited slot takes a read phase, then an update phase. Create writes its
// slot on acceptance; sleep, receive and the unused code read the current
// slot and may update it; kill and send walk the table for a pid match;
// switch and exit make a find-minimum pass then a countdown pass, the latter
// skipped when no task is left. The input stalls until the result enters
// the output register; the next word can be taken in the cycle after. A
// result waiting on the output side holds back only the next result. Slot 0
// is written during reset; other records are only read behind their valid
// bit, so no clearing pass is needed.
module round_robin_task_scheduler (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrts_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrts_pkg::out_word_t out_data
);
  import rrts_pkg::*;

  slot_t             mem [TASK_SLOTS];
  logic [31:0]       mail [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] valid, mfull;
  slot_t             rd;
  logic [31:0]       mail_rd;

  state_t            state, state_next;
  in_word_t          cur;
  logic [SW-1:0]     cur_slot;
  logic [15:0]       pid_counter;
  logic [SW-1:0]     idx;        // slot being visited
  logic [SW:0]       cnt;        // steps taken
  logic              phase;      // 0 read issued, 1 data valid
  logic [1:0]        pass;       // 0 single, 1 min search, 2 countdown
  logic              any;
  logic [15:0]       best;
  logic [SW:0]       bidx;
  logic [SW-1:0]     hit;
  logic              found;
  logic [2:0]        st;
  logic [31:0]       mo;
  logic              created;
  logic [15:0]       new_pid;

  logic              we;
  logic [SW-1:0]     waddr, raddr;
  slot_t             wdat;
  logic              mwe;

  logic [SW-1:0]     first_free;
  logic              any_free;
  logic [SW:0]       k_pos;
  logic              pid_cmd, scan_last, pid_hit, load_out;

  always_comb begin
    first_free = '0;
    any_free = 1'b0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        first_free = SW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdat;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (mwe) mail[hit] <= cur.msg_word;
    mail_rd <= mail[cur_slot];
  end

  assign in_stall = (state != S_IDLE);
  assign k_pos = cnt + (SW+1)'(1);
  assign pid_cmd = (cmd_t'(cur.cmd) == CMD_KILL) || (cmd_t'(cur.cmd) == CMD_SEND);
  assign scan_last = (cnt == (SW+1)'(TASK_SLOTS - 1));
  assign pid_hit = valid[idx] && (rd.pid == cur.target_pid);
  assign load_out = (state == S_DONE) && phase && (cnt == (SW+1)'(2)) &&
                    (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = idx;
    wdat = rd;
    mwe = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_data.cmd))
            CMD_SWITCH, CMD_EXIT, CMD_KILL, CMD_SEND: state_next = S_SCAN;
            CMD_CREATE: begin
              state_next = S_DONE;
              if (any_free) begin
                we = 1'b1;
                waddr = first_free;
                wdat = '{pid: pid_counter, sleep: '0, tstat: TS_READY, runs: '0};
              end
            end
            default: state_next = S_FIX;
          endcase
        end
      end
      S_SCAN: begin
        if (phase) begin
          if (pid_cmd) begin
            if (pid_hit || scan_last) state_next = S_FIX;
          end else if (pass == 2'd1) begin
            if (scan_last && !(any || valid[idx])) state_next = S_DONE;
          end else begin
            if (valid[idx]) begin
              we = 1'b1;
              waddr = idx;
              if (k_pos == bidx) begin
                wdat.sleep = rd.sleep - best;
                wdat.tstat = TS_RUNNING;
                wdat.runs = rd.runs + 32'd1;
              end else if (k_pos < bidx) begin
                wdat.sleep = rd.sleep - best - 16'd1;
              end else begin
                wdat.sleep = rd.sleep - best;
              end
            end
            if (scan_last) state_next = S_DONE;
          end
        end
      end
      S_FIX: begin
        if (phase) begin
          state_next = S_DONE;
          case (cmd_t'(cur.cmd))
            CMD_SEND: begin
              if (found && rd.tstat == TS_LISTENING) mwe = 1'b1;
            end
            CMD_SLEEP: begin
              if (valid[cur_slot]) begin
                we = 1'b1;
                waddr = cur_slot;
                wdat.sleep = cur.sleep_ticks;
                wdat.tstat = TS_SLEEPING;
              end
            end
            CMD_RECEIVE: begin
              if (valid[cur_slot] && !mfull[cur_slot]) begin
                we = 1'b1;
                waddr = cur_slot;
                wdat.tstat = TS_LISTENING;
              end
            end
            default: ;
          endcase
        end
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (rst) begin
      state_next = S_IDLE;
      we = 1'b1;
      waddr = '0;
      wdat = '{pid: 16'd1, sleep: '0, tstat: TS_READY, runs: '0};
      mwe = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= TASK_SLOTS'(1);
      mfull <= '0;
      cur_slot <= '0;
      pid_counter <= 16'd2;
      phase <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            st <= (cmd_t'(in_data.cmd) == CMD_CREATE && !any_free) ? RS_FULL : RS_OK;
            mo <= '0;
            created <= (cmd_t'(in_data.cmd) == CMD_CREATE) && any_free;
            phase <= 1'b0;
            cnt <= '0;
            any <= 1'b0;
            found <= 1'b0;
            case (cmd_t'(in_data.cmd))
              CMD_SWITCH, CMD_EXIT: begin
                if (cmd_t'(in_data.cmd) == CMD_EXIT) valid[cur_slot] <= 1'b0;
                pass <= 2'd1;
                idx <= cur_slot + SW'(1);
                raddr <= cur_slot + SW'(1);
              end
              CMD_KILL, CMD_SEND: begin
                pass <= 2'd1;
                idx <= '0;
                raddr <= '0;
              end
              CMD_CREATE: begin
                if (any_free) begin
                  valid[first_free] <= 1'b1;
                  mfull[first_free] <= 1'b0;
                  new_pid <= pid_counter;
                  pid_counter <= pid_counter + 16'd1;
                end
              end
              default: begin
                pass <= 2'd0;
                raddr <= cur_slot;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one slot per visit: read issued, then data used
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (pid_cmd) begin
              if (pid_hit) begin
                found <= 1'b1;
                hit <= idx;
              end else if (!scan_last) begin
                cnt <= cnt + (SW+1)'(1);
                idx <= idx + SW'(1);
                raddr <= idx + SW'(1);
              end
            end else if (pass == 2'd1) begin
              if (valid[idx] && (!any || rd.sleep < best)) begin
                best <= rd.sleep;
                bidx <= k_pos;
                any <= 1'b1;
              end
              if (scan_last) begin
                cnt <= '0;
                pass <= 2'd2;
                idx <= cur_slot + SW'(1);
                raddr <= cur_slot + SW'(1);
                if (!(any || valid[idx])) st <= RS_NO_TASK;
              end else begin
                cnt <= cnt + (SW+1)'(1);
                idx <= idx + SW'(1);
                raddr <= idx + SW'(1);
              end
            end else begin
              if (scan_last) begin
                cur_slot <= cur_slot + SW'(bidx);
              end else begin
                cnt <= cnt + (SW+1)'(1);
                idx <= idx + SW'(1);
                raddr <= idx + SW'(1);
              end
            end
          end
        end
        S_FIX: begin
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            case (cmd_t'(cur.cmd))
              CMD_KILL: begin
                if (found) valid[hit] <= 1'b0;
                else st <= RS_NO_PID;
              end
              CMD_SEND: begin
                if (!found) st <= RS_NO_PID;
                else if (rd.tstat != TS_LISTENING) st <= RS_NOT_LISTN;
                else mfull[hit] <= 1'b1;
              end
              CMD_SLEEP: begin
                if (!valid[cur_slot]) st <= RS_NO_TASK;
              end
              CMD_RECEIVE: begin
                if (!valid[cur_slot]) st <= RS_NO_TASK;
                else if (mfull[cur_slot]) begin
                  mo <= mail_rd;
                  mfull[cur_slot] <= 1'b0;
                end else st <= RS_NO_MSG;
              end
              default: ;
            endcase
          end
        end
        S_DONE: begin
          // read back the current slot after any write lands
          if (!phase) begin
            raddr <= cur_slot;
            phase <= 1'b1;
            cnt <= '0;
          end else if (cnt != (SW+1)'(2)) begin
            cnt <= cnt + (SW+1)'(1);
          end else if (load_out) begin
            phase <= 1'b0;
            out_data <= '{status: st,
                          result_pid: created ? new_pid :
                                      (valid[cur_slot] ? rd.pid : 16'd0),
                          current_slot_out: 4'(cur_slot),
                          run_count: valid[cur_slot] ? rd.runs : 32'd0,
                          msg_out: mo};
          end
        end
        default: ;
      endcase
    end
  end
endmodule
